// File: design/weight_one_eisenstein_coefficients_assert.svh
// assertion macros for the coefficient block checker
`ifndef WEIGHT_ONE_EISENSTEIN_COEFFICIENTS_ASSERT_SVH
`define WEIGHT_ONE_EISENSTEIN_COEFFICIENTS_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define WOEC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is low
`define WOEC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/woec_pkg.sv
package woec_pkg;

  localparam int unsigned INDEX_BITS_DEF = 16;
  localparam int unsigned IN_DATA_W      = 16;
  localparam int unsigned FIELD_W        = 12;
  localparam int unsigned OUT_DATA_W     = 40;
  localparam int unsigned SCALED_W       = 15;

  typedef logic signed [FIELD_W-1:0]  sum_t;
  typedef logic signed [SCALED_W-1:0] scaled_t;
  typedef logic signed [1:0]          chi_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_ACC,
    ST_FINISH
  } state_e;

  function automatic chi_t chi3(input logic [1:0] r);
    chi_t c;
    unique case (r)
      2'd1:    c = 2'sb01;
      2'd2:    c = 2'sb11;
      default: c = 2'sb00;
    endcase
    return c;
  endfunction

  function automatic chi_t chi4(input logic [1:0] r);
    chi_t c;
    unique case (r)
      2'd1:    c = 2'sb01;
      2'd3:    c = 2'sb11;
      default: c = 2'sb00;
    endcase
    return c;
  endfunction

  function automatic chi_t chi7(input logic [2:0] r);
    chi_t c;
    unique case (r)
      3'd1, 3'd2, 3'd4: c = 2'sb01;
      3'd0:             c = 2'sb00;
      default:          c = 2'sb11;
    endcase
    return c;
  endfunction

  function automatic sum_t widen(input chi_t c);
    return {{(FIELD_W-2){c[1]}}, c};
  endfunction

  function automatic logic [FIELD_W-1:0] clamp(input scaled_t v);
    logic [FIELD_W-1:0] r;
    if (v < -15'sd1024) begin
      r = 12'hC00;
    end else if (v > 15'sd1024) begin
      r = 12'h400;
    end else begin
      r = v[FIELD_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: design/weight_one_eisenstein_coefficients.sv
// timing: index zero goes from idle straight to the finish state; any other index
// loops through the check, divide and accumulate states once per candidate divisor,
// using a single bit-serial divider that works through every index bit per divisor
// throughput: one item at a time, input ready again once the result is registered
// reset: asynchronous active low, returns to idle with no result pending
module weight_one_eisenstein_coefficients #(
  parameter int unsigned INDEX_BITS = woec_pkg::INDEX_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [woec_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // index
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [woec_pkg::OUT_DATA_W-1:0] m_axis_tdata    // coeff_mod3, coeff_mod4, coeff_mod7, pad
);

  localparam int unsigned NB = INDEX_BITS;
  localparam int unsigned DW = NB / 2 + 1;
  localparam int unsigned CW = $clog2(NB);
  localparam int unsigned FW = woec_pkg::FIELD_W;

  woec_pkg::state_e state_q, state_d;

  logic [NB-1:0] n_q, n_d;
  logic [DW-1:0] d_q, d_d;
  logic [1:0]    d3_q, d3_d;
  logic [2:0]    d7_q, d7_d;
  logic [NB:0]   sq_q, sq_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [NB-1:0] quo_q, quo_d;
  logic [1:0]    qr3_q, qr3_d;
  logic [2:0]    qr7_q, qr7_d;
  logic [CW-1:0] cnt_q, cnt_d;
  woec_pkg::sum_t s3_q, s3_d, s4_q, s4_d, s7_q, s7_d;
  logic          zero_q, zero_d;
  logic          out_valid_q, out_valid_d;
  logic [woec_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic [woec_pkg::IN_DATA_W+NB-1:0] in_ext;
  logic [NB-1:0] n_in;
  logic [DW:0]   rem_sh, rem_sub;
  logic          qbit;
  logic [2:0]    r3_t;
  logic [3:0]    r7_t;
  logic [NB-1:0] d_ext;
  woec_pkg::scaled_t sc3, sc4, sc7;

  assign in_ext  = {{NB{1'b0}}, s_axis_tdata};
  assign n_in    = in_ext[NB-1:0];
  assign rem_sh  = {rem_q, n_q[cnt_q]};
  assign qbit    = rem_sh >= {1'b0, d_q};
  assign rem_sub = rem_sh - {1'b0, d_q};
  assign r3_t    = {qr3_q, qbit};
  assign r7_t    = {qr7_q, qbit};
  assign d_ext   = {{(NB-DW){1'b0}}, d_q};

  // scale by 6, 4 and 2 with shifts
  assign sc3 = ({{3{s3_q[FW-1]}}, s3_q} <<< 2) + ({{3{s3_q[FW-1]}}, s3_q} <<< 1);
  assign sc4 = {{3{s4_q[FW-1]}}, s4_q} <<< 2;
  assign sc7 = {{3{s7_q[FW-1]}}, s7_q} <<< 1;

  assign s_axis_tready = (state_q == woec_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    d_d         = d_q;
    d3_d        = d3_q;
    d7_d        = d7_q;
    sq_d        = sq_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    qr3_d       = qr3_q;
    qr7_d       = qr7_q;
    cnt_d       = cnt_q;
    s3_d        = s3_q;
    s4_d        = s4_q;
    s7_d        = s7_q;
    zero_d      = zero_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      woec_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          n_d     = n_in;
          d_d     = DW'(1);
          d3_d    = 2'd1;
          d7_d    = 3'd1;
          sq_d    = (NB+1)'(1);
          s3_d    = '0;
          s4_d    = '0;
          s7_d    = '0;
          zero_d  = (n_in == '0);
          state_d = (n_in == '0) ? woec_pkg::ST_FINISH : woec_pkg::ST_CHECK;
        end
      end
      woec_pkg::ST_CHECK: begin
        if (sq_q <= {1'b0, n_q}) begin
          rem_d   = '0;
          quo_d   = '0;
          qr3_d   = '0;
          qr7_d   = '0;
          cnt_d   = CW'(NB - 1);
          state_d = woec_pkg::ST_DIV;
        end else begin
          state_d = woec_pkg::ST_FINISH;
        end
      end
      woec_pkg::ST_DIV: begin
        // one quotient bit a cycle, quotient residues mod 3 and 7 kept alongside
        rem_d = qbit ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        quo_d = {quo_q[NB-2:0], qbit};
        qr3_d = (r3_t >= 3'd3) ? 2'(r3_t - 3'd3) : r3_t[1:0];
        qr7_d = (r7_t >= 4'd7) ? 3'(r7_t - 4'd7) : r7_t[2:0];
        if (cnt_q == '0) begin
          state_d = woec_pkg::ST_ACC;
        end else begin
          cnt_d = cnt_q - CW'(1);
        end
      end
      woec_pkg::ST_ACC: begin
        if (rem_q == '0) begin
          if (quo_q != d_ext) begin
            s3_d = s3_q + woec_pkg::widen(woec_pkg::chi3(d3_q))
                        + woec_pkg::widen(woec_pkg::chi3(qr3_q));
            s4_d = s4_q + woec_pkg::widen(woec_pkg::chi4(d_q[1:0]))
                        + woec_pkg::widen(woec_pkg::chi4(quo_q[1:0]));
            s7_d = s7_q + woec_pkg::widen(woec_pkg::chi7(d7_q))
                        + woec_pkg::widen(woec_pkg::chi7(qr7_q));
          end else begin
            s3_d = s3_q + woec_pkg::widen(woec_pkg::chi3(d3_q));
            s4_d = s4_q + woec_pkg::widen(woec_pkg::chi4(d_q[1:0]));
            s7_d = s7_q + woec_pkg::widen(woec_pkg::chi7(d7_q));
          end
        end
        sq_d    = sq_q + {{(NB-DW){1'b0}}, d_q, 1'b1};
        d_d     = d_q + DW'(1);
        d3_d    = (d3_q == 2'd2) ? 2'd0 : d3_q + 2'd1;
        d7_d    = (d7_q == 3'd6) ? 3'd0 : d7_q + 3'd1;
        state_d = woec_pkg::ST_CHECK;
      end
      woec_pkg::ST_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          if (zero_q) begin
            out_data_d = {4'd0, FW'(1), FW'(1), FW'(1)};
          end else begin
            out_data_d = {4'd0, woec_pkg::clamp(sc7), woec_pkg::clamp(sc4),
                          woec_pkg::clamp(sc3)};
          end
          state_d = woec_pkg::ST_IDLE;
        end
      end
      default: state_d = woec_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= woec_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    d_q        <= d_d;
    d3_q       <= d3_d;
    d7_q       <= d7_d;
    sq_q       <= sq_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    qr3_q      <= qr3_d;
    qr7_q      <= qr7_d;
    cnt_q      <= cnt_d;
    s3_q       <= s3_d;
    s4_q       <= s4_d;
    s7_q       <= s7_d;
    zero_q     <= zero_d;
    out_data_q <= out_data_d;
  end

endmodule

// File: design/woec_checker.sv
`include "weight_one_eisenstein_coefficients_assert.svh"

module woec_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [woec_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  // block is busy right after taking an item
  `WOEC_ASSERT_NXT(busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready right after accept")

  // stalled result holds
  `WOEC_ASSERT_NXT(out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // mod 4 field is a multiple of four unless it is the constant term
  `WOEC_ASSERT_IMP(mod4_scaled, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[13:12] != 2'b01, m_axis_tdata[13:12] == 2'b00, "mod 4 coefficient not scaled")

  // an odd mod 7 field only comes from index zero, where all fields are one
  `WOEC_ASSERT_IMP(const_term, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[24], m_axis_tdata[11:0] == 12'd1 && m_axis_tdata[23:12] == 12'd1 && m_axis_tdata[35:24] == 12'd1, "bad constant term")

endmodule

bind weight_one_eisenstein_coefficients woec_checker u_woec_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: tb/tb.sv
module tb;

  localparam int unsigned IDX_W       = woec_pkg::IN_DATA_W;
  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned LONG_HOLD   = 3000;
  localparam int unsigned TAIL_CYCLES = 5000;

  typedef struct packed {
    woec_pkg::sum_t mod3;
    woec_pkg::sum_t mod4;
    woec_pkg::sum_t mod7;
  } coeff_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            s_tvalid = 1'b0;
  logic [IDX_W-1:0]                s_tdata = '0;
  logic                            m_tready = 1'b0;
  logic                            s_axis_tready;
  logic                            m_axis_tvalid;
  logic [woec_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  coeff_t      coeff_q[$];
  int unsigned mismatches = 0;
  int unsigned indices_sent = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;
  int unsigned rx_hold = 0;
  bit          no_idle = 1'b0;

  weight_one_eisenstein_coefficients dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),        // index
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata)    // coeff_mod3, coeff_mod4, coeff_mod7, pad
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $time, coeff_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int chi_three(int unsigned d);
    case (d % 3)
      1:       return 1;
      2:       return -1;
      default: return 0;
    endcase
  endfunction

  function automatic int chi_four(int unsigned d);
    case (d % 4)
      1:       return 1;
      3:       return -1;
      default: return 0;
    endcase
  endfunction

  function automatic int chi_seven(int unsigned d);
    case (d % 7)
      1, 2, 4: return 1;
      0:       return 0;
      default: return -1;
    endcase
  endfunction

  function automatic woec_pkg::sum_t saturate(int v);
    if (v < -1024) v = -1024;
    if (v > 1024) v = 1024;
    return woec_pkg::sum_t'(v);
  endfunction

  function automatic coeff_t eisenstein_coeffs(logic [IDX_W-1:0] idx);
    int unsigned n;
    int unsigned d;
    int unsigned e;
    int          s3;
    int          s4;
    int          s7;
    coeff_t      c;
    n  = 32'(idx);
    s3 = 0;
    s4 = 0;
    s7 = 0;
    if (n == 0) begin
      c.mod3 = woec_pkg::sum_t'(1);
      c.mod4 = woec_pkg::sum_t'(1);
      c.mod7 = woec_pkg::sum_t'(1);
      return c;
    end
    for (d = 1; d * d <= n; d++) begin
      if (n % d == 0) begin
        e = n / d;
        s3 += chi_three(d);
        s4 += chi_four(d);
        s7 += chi_seven(d);
        if (e != d) begin
          s3 += chi_three(e);
          s4 += chi_four(e);
          s7 += chi_seven(e);
        end
      end
    end
    c.mod3 = saturate(6 * s3);
    c.mod4 = saturate(4 * s4);
    c.mod7 = saturate(2 * s7);
    return c;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_index(logic [IDX_W-1:0] idx);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= idx;
    do @(posedge clk); while (!s_axis_tready);
    coeff_q = {coeff_q, eisenstein_coeffs(idx)};
    indices_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (coeff_q.size() != 0) @(negedge clk);
  endtask

  // mostly small indices keep the run short; a few full-width ones reach the top bits
  function automatic logic [IDX_W-1:0] random_index();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return IDX_W'($urandom_range(0, 1023));
    if (pick < 88) return IDX_W'($urandom_range(1024, 8191));
    return IDX_W'($urandom_range(0, 65535));
  endfunction

  // result checker
  always @(posedge clk) begin
    coeff_t exp_c;
    coeff_t got_c;
    if (rst_n && m_axis_tvalid && m_tready) begin
      results_seen++;
      got_c.mod3 = m_axis_tdata[11:0];
      got_c.mod4 = m_axis_tdata[23:12];
      got_c.mod7 = m_axis_tdata[35:24];
      if (coeff_q.size() == 0) begin
        $display("%0t unexpected item: actual %h", $time, m_axis_tdata);
        mismatches++;
      end else begin
        exp_c = coeff_q.pop_front();
        if (got_c.mod3 !== exp_c.mod3) begin
          $display("%0t coeff_mod3: expected %0d actual %0d", $time, exp_c.mod3, got_c.mod3);
          mismatches++;
        end
        if (got_c.mod4 !== exp_c.mod4) begin
          $display("%0t coeff_mod4: expected %0d actual %0d", $time, exp_c.mod4, got_c.mod4);
          mismatches++;
        end
        if (got_c.mod7 !== exp_c.mod7) begin
          $display("%0t coeff_mod7: expected %0d actual %0d", $time, exp_c.mod7, got_c.mod7);
          mismatches++;
        end
        if (m_axis_tdata[39:36] !== 4'h0) begin
          $display("%0t pad: expected 0 actual %h", $time, m_axis_tdata[39:36]);
          mismatches++;
        end
      end
    end
  end

  // result side back-pressure
  initial begin
    int unsigned wait_c;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (rx_hold != 0) begin
        wait_c  = rx_hold;
        rx_hold = 0;
      end else if (no_idle) begin
        wait_c = 0;
      end else begin
        wait_c = $urandom_range(0, 17);
      end
      if (wait_c != 0) begin
        m_tready <= 1'b0;
        repeat (wait_c) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      @(negedge clk);
    end
  end

  task automatic test_directed();
    logic [IDX_W-1:0] idx_list[] = '{
      16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7, 16'd9, 16'd12,
      16'd21, 16'd49, 16'd84, 16'd255, 16'd256, 16'd1000, 16'd4096, 16'd21845,
      16'd43690, 16'd32768, 16'd65025, 16'd65521, 16'd65534, 16'd65535
    };
    foreach (idx_list[i]) send_index(idx_list[i]);
    drain();
  endtask

  // receiver stalls long while the sender keeps offering
  task automatic test_backpressure();
    no_idle = 1'b1;
    rx_hold = LONG_HOLD;
    repeat (5) send_index(IDX_W'($urandom_range(0, 63)));
    no_idle = 1'b0;
    drain();
  endtask

  task automatic test_random_gaps();
    repeat (60) send_index(random_index());
    drain();
  endtask

  task automatic test_random_mixed();
    repeat (25) send_index(random_index());
    no_idle = 1'b1;
    repeat (25) send_index(random_index());
    no_idle = 1'b0;
    repeat (10) send_index(random_index());
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_backpressure();
    test_random_gaps();
    test_random_mixed();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("sent %0d indices (edge values, long receiver stall, random gaps and bursts)",
             indices_sent);
    $display("compared %0d results, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && coeff_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/woec_pkg.sv
design/weight_one_eisenstein_coefficients.sv
design/woec_checker.sv
tb/tb.sv
